// File: sv/id3fte_pkg.sv
// Shared types, codes and constants for the ID3v2.3 frame text extractor.
package id3fte_pkg;

    localparam int DATA_W     = 8;
    localparam int WORD_W     = 32;
    localparam int FIELD_W    = 3;
    localparam int KIND_W     = 2;
    localparam int PHASE_W    = 3;
    localparam int POS_W      = 3;
    localparam int FOUND_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_IDS    = 6;
    localparam int MAX_TAGS   = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_DATA_W = 16;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_HDR_ID   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR_VER  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HDR_SKIP = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FR_ID    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FR_SIZE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FR_FLAGS = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_STOP     = 3'd7;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOF     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TITLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARTIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALBUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GENRE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMENT = 3'd5;

    // Reset frame ids, four characters packed big-endian.
    localparam logic [WORD_W-1:0] RST_TITLE   = 32'h5449_5432;
    localparam logic [WORD_W-1:0] RST_ARTIST  = 32'h5450_4531;
    localparam logic [WORD_W-1:0] RST_ALBUM   = 32'h5441_4C42;
    localparam logic [WORD_W-1:0] RST_YEAR    = 32'h5459_4552;
    localparam logic [WORD_W-1:0] RST_GENRE   = 32'h5443_4F4E;
    localparam logic [WORD_W-1:0] RST_COMMENT = 32'h434F_4D4D;

    localparam logic [23:0] TAG_MAGIC   = 24'h49_4433;
    localparam logic [15:0] TAG_VERSION = 16'h0300;

    // Byte positions at which each phase completes.
    localparam logic [POS_W-1:0] LEN_HDR_ID   = 3'd3;
    localparam logic [POS_W-1:0] LEN_HDR_VER  = 3'd2;
    localparam logic [POS_W-1:0] LEN_HDR_SKIP = 3'd5;
    localparam logic [POS_W-1:0] LEN_FR_ID    = 3'd4;
    localparam logic [POS_W-1:0] LEN_FR_SIZE  = 3'd4;
    localparam logic [POS_W-1:0] LEN_FR_FLAGS = 3'd2;

    // Results caused by one input byte, queued between front and back.
    typedef struct packed {
        logic                content;
        logic                eof;
        logic                done;
        logic                reject;
        logic [FIELD_W-1:0]  field;
        logic [DATA_W-1:0]   value;
    } cmd_t;

endpackage

// File: sv/id3fte_front.sv
// Front end: holds the frame ids, parses each byte and builds its result set.
module id3fte_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [id3fte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [id3fte_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                             accept,
    input  logic [id3fte_pkg::DATA_W-1:0]    data_byte,
    input  logic                             first,
    output logic                             push,
    output id3fte_pkg::cmd_t                 cmd
);
    import id3fte_pkg::*;

    logic [WORD_W-1:0]  ids_reg [NUM_IDS];

    logic [PHASE_W-1:0] phase_reg, phase_next, phase_e;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_e;
    logic [WORD_W-1:0]  shift_reg, shift_next, shift_e;
    logic [WORD_W-1:0]  left_reg, left_next, left_e;
    logic [FIELD_W-1:0] mfield_reg, mfield_next, mfield_e;
    logic               mflag_reg, mflag_next, mflag_e;
    logic [FOUND_W-1:0] found_reg, found_next, found_e;
    logic               do_finish;
    logic               hit;
    logic [FIELD_W-1:0] hit_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_reg[REG_TITLE]   <= RST_TITLE;
            ids_reg[REG_ARTIST]  <= RST_ARTIST;
            ids_reg[REG_ALBUM]   <= RST_ALBUM;
            ids_reg[REG_YEAR]    <= RST_YEAR;
            ids_reg[REG_GENRE]   <= RST_GENRE;
            ids_reg[REG_COMMENT] <= RST_COMMENT;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_IDS)))
        begin
            ids_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Frame id match; the lowest matching field index wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--)
        begin
            if (ids_reg[i] == shift_next)
            begin
                hit     = 1'b1;
                hit_idx = FIELD_W'(i);
            end
        end
    end

    always_comb
    begin
        // A first byte restarts the parse before it is itself consumed.
        phase_e  = first ? PH_HDR_ID : phase_reg;
        pos_e    = first ? '0 : pos_reg;
        shift_e  = first ? '0 : shift_reg;
        left_e   = first ? '0 : left_reg;
        mfield_e = first ? '0 : mfield_reg;
        mflag_e  = first ? 1'b0 : mflag_reg;
        found_e  = first ? '0 : found_reg;

        phase_next  = phase_e;
        pos_next    = pos_e;
        shift_next  = shift_e;
        left_next   = left_e;
        mfield_next = mfield_e;
        mflag_next  = mflag_e;
        found_next  = found_e;
        do_finish   = 1'b0;
        cmd         = '0;

        if (phase_e != PH_STOP && phase_e != PH_PAYLOAD)
        begin
            shift_next = {shift_e[WORD_W-DATA_W-1:0], data_byte};
            pos_next   = pos_e + 1'b1;
        end

        case (phase_e)
            PH_HDR_ID:
            begin
                if (pos_next == LEN_HDR_ID)
                begin
                    pos_next = '0;
                    if (shift_next[23:0] != TAG_MAGIC)
                    begin
                        cmd.reject = 1'b1;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        phase_next = PH_HDR_VER;
                    end
                end
            end
            PH_HDR_VER:
            begin
                if (pos_next == LEN_HDR_VER)
                begin
                    pos_next = '0;
                    if (shift_next[15:0] != TAG_VERSION)
                    begin
                        cmd.reject = 1'b1;
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        phase_next = PH_HDR_SKIP;
                    end
                end
            end
            PH_HDR_SKIP:
            begin
                if (pos_next == LEN_HDR_SKIP)
                begin
                    pos_next   = '0;
                    phase_next = PH_FR_ID;
                end
            end
            PH_FR_ID:
            begin
                if (pos_next == LEN_FR_ID)
                begin
                    pos_next    = '0;
                    phase_next  = PH_FR_SIZE;
                    mflag_next  = hit;
                    mfield_next = hit_idx;
                    if (hit)
                    begin
                        found_next = found_e + 1'b1;
                    end
                end
            end
            PH_FR_SIZE:
            begin
                if (pos_next == LEN_FR_SIZE)
                begin
                    pos_next   = '0;
                    left_next  = shift_next;
                    phase_next = PH_FR_FLAGS;
                end
            end
            PH_FR_FLAGS:
            begin
                if (pos_next == LEN_FR_FLAGS)
                begin
                    pos_next = '0;
                    if (left_e == '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (mflag_e && (data_byte != '0))
                begin
                    cmd.content = 1'b1;
                    cmd.value   = data_byte;
                end
                left_next = left_e - 1'b1;
                if (left_next == '0)
                begin
                    do_finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_finish)
        begin
            pos_next   = '0;
            phase_next = PH_FR_ID;
            if (mflag_e)
            begin
                cmd.eof    = 1'b1;
                mflag_next = 1'b0;
                if (found_e >= FOUND_W'(MAX_TAGS))
                begin
                    cmd.done   = 1'b1;
                    phase_next = PH_STOP;
                end
            end
        end

        if (cmd.content || cmd.eof)
        begin
            cmd.field = mfield_e;
        end
    end

    assign push = accept && (cmd.content || cmd.eof || cmd.done || cmd.reject);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_ID;
            pos_reg    <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            mfield_reg <= '0;
            mflag_reg  <= 1'b0;
            found_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            mfield_reg <= mfield_next;
            mflag_reg  <= mflag_next;
            found_reg  <= found_next;
        end
    end

endmodule

// File: sv/id3fte_cmd_fifo.sv
// Short queue of result sets between the parser and the output serialiser.
module id3fte_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  id3fte_pkg::cmd_t din,
    input  logic             pop,
    output id3fte_pkg::cmd_t dout,
    output logic             full,
    output logic             empty
);
    import id3fte_pkg::*;

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/id3fte_back.sv
// Back end: unpacks each queued result set into single results on the output register.
module id3fte_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  id3fte_pkg::cmd_t                    head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [id3fte_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                m_tlast
);
    import id3fte_pkg::*;

    // Mask bit order is the order of emission.
    localparam int MB_CONTENT = 0;
    localparam int MB_EOF     = 1;
    localparam int MB_DONE    = 2;
    localparam int MB_REJECT  = 3;

    logic [3:0]         pend_reg, pend_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               valid_reg, valid_next;
    logic [KIND_W-1:0]  okind_reg, okind_next;
    logic [FIELD_W-1:0] ofield_reg, ofield_next;
    logic [DATA_W-1:0]  ovalue_reg, ovalue_next;
    logic               olast_reg, olast_next;

    logic               have_pend;
    logic               load;
    logic [3:0]         src_mask;
    logic [3:0]         pick;
    logic [FIELD_W-1:0] src_field;
    logic [DATA_W-1:0]  src_value;

    assign have_pend = (pend_reg != '0);
    assign load      = !valid_reg || m_tready;
    assign src_mask  = have_pend ? pend_reg : {head.reject, head.done, head.eof, head.content};
    assign src_field = have_pend ? field_reg : head.field;
    assign src_value = have_pend ? value_reg : head.value;

    always_comb
    begin
        pick        = '0;
        pend_next   = pend_reg;
        field_next  = field_reg;
        value_next  = value_reg;
        valid_next  = valid_reg;
        okind_next  = okind_reg;
        ofield_next = ofield_reg;
        ovalue_next = ovalue_reg;
        olast_next  = olast_reg;
        pop         = 1'b0;

        if (src_mask[MB_CONTENT])
        begin
            pick[MB_CONTENT] = 1'b1;
        end
        else if (src_mask[MB_EOF])
        begin
            pick[MB_EOF] = 1'b1;
        end
        else if (src_mask[MB_DONE])
        begin
            pick[MB_DONE] = 1'b1;
        end
        else
        begin
            pick[MB_REJECT] = src_mask[MB_REJECT];
        end

        if (load)
        begin
            if (have_pend || !empty)
            begin
                pop         = !have_pend;
                valid_next  = 1'b1;
                pend_next   = src_mask & ~pick;
                field_next  = src_field;
                value_next  = src_value;
                olast_next  = ((src_mask & ~pick) == '0);
                ofield_next = '0;
                ovalue_next = '0;
                if (pick[MB_CONTENT])
                begin
                    okind_next  = KIND_CONTENT;
                    ofield_next = src_field;
                    ovalue_next = src_value;
                end
                else if (pick[MB_EOF])
                begin
                    okind_next  = KIND_EOF;
                    ofield_next = src_field;
                end
                else if (pick[MB_DONE])
                begin
                    okind_next = KIND_DONE;
                end
                else
                begin
                    okind_next = KIND_REJECT;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        field_reg  <= field_next;
        value_reg  <= value_next;
        okind_reg  <= okind_next;
        ofield_reg <= ofield_next;
        ovalue_reg <= ovalue_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{(OUT_DATA_W - DATA_W - FIELD_W - KIND_W){1'b0}},
                       ovalue_reg, ofield_reg, okind_reg};

endmodule

// File: sv/id3fte_top_unused_guard.sv
// Input flow control: the slave side is ready whenever the result queue has room.
module id3fte_top_unused_guard (
    input  logic full,
    output logic s_ready
);
    assign s_ready = !full;
endmodule

// File: sv/id3v2_frame_text_extractor.sv
// Top level of the ID3v2.3 frame text extractor.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tdata: data_byte; tuser: first
//  m_*     | out       | m_tvalid/m_tready  | tdata: kind, field, value; tlast: last
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_wdata
//
// One input byte is taken per cycle while the result queue has room. The back end sends
// one result per cycle while m_tready is high, so a byte that causes two or three
// results (end of a matched frame) goes out as that many results in turn, and the
// four-entry queue absorbs the difference. Reset clears the parse state, the queue and
// the output register, and loads the default frame ids. A stalled output fills the
// queue and then holds s_tready low.
module id3v2_frame_text_extractor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [id3fte_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] first
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [id3fte_pkg::OUT_DATA_W-1:0]   m_tdata,   // [1:0] kind, [4:2] field, [12:5] value
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [id3fte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [id3fte_pkg::WORD_W-1:0]       cfg_wdata
);
    import id3fte_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;
    logic accept;

    assign accept = s_tvalid && s_tready;

    id3fte_top_unused_guard u_guard (
        .full    (full),
        .s_ready (s_tready)
    );

    id3fte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_byte (s_tdata),
        .first     (s_tuser),
        .push      (push),
        .cmd       (push_cmd)
    );

    id3fte_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .full  (full),
        .empty (empty)
    );

    id3fte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_cmd),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
